// ===== design/slist_pkg.sv =====
// ----------------------------------------------------------------------------
// slist_pkg
// shared constants, codes and control types of the sorted list intersection
// ----------------------------------------------------------------------------
package slist_pkg;

	localparam int LIST_DEPTH  = 32;
	localparam int MAX_RESULTS = 32;
	localparam int DATA_W      = 32;
	localparam int ADDR_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CNT_W       = $clog2(LIST_DEPTH + 1);
	localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

	typedef enum logic [1:0] {
		CMD_APPEND_A = 2'd0,
		CMD_APPEND_B = 2'd1,
		CMD_RUN      = 2'd2,
		CMD_NONE     = 2'd3
	} command_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_CMP,
		ST_FLUSH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic run_start;
		logic step_eq;
		logic step_a;
		logic step_b;
		logic finish;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic walk_go;
		logic eq;
		logic a_less;
		logic pend_valid;
		logic out_free;
	} dp_status_t;

endpackage

// ===== design/slist_in_if.sv =====
// ----------------------------------------------------------------------------
// slist_in_if
// request channel: command and value with valid/ready
// ----------------------------------------------------------------------------
interface slist_in_if;
	logic                                valid;
	logic                                ready;
	logic [1:0]                          command;
	logic signed [slist_pkg::DATA_W-1:0] value;

	modport source (output valid, output command, output value, input ready);
	modport sink   (input valid, input command, input value, output ready);
endinterface

// ===== design/slist_out_if.sv =====
// ----------------------------------------------------------------------------
// slist_out_if
// result channel: common value and flags with valid/ready
// ----------------------------------------------------------------------------
interface slist_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [slist_pkg::DATA_W-1:0] common_value;
	logic                                empty_result;
	logic                                overflowed;
	logic                                last;

	modport source (output valid, output common_value, output empty_result,
		output overflowed, output last, input ready);
	modport sink   (input valid, input common_value, input empty_result,
		input overflowed, input last, output ready);
endinterface

// ===== design/sorted_list_intersection.sv =====
// ----------------------------------------------------------------------------
// sorted_list_intersection
// two-pointer intersection of two sorted lists of signed 32-bit values
// ----------------------------------------------------------------------------
// usage
// - request channel takes one word per command: append to list a, append to
//   list b, or run; an unknown command is taken and ignored
// - appends give no result; an append to a full list
//   is dropped and sets a sticky overflow flag, cleared only by reset
// - a run walks both lists; each walk step is a ram read, then a compare,
//   and a run takes at most count_a + count_b - 1 steps; the registered ram
//   read port is why each step has a read state before its compare state
// - each match comes out as one result word; the last one carries last, and
//   an empty intersection gives one word with empty_result and last set
// - a match is held until the next one is found so that last is known
// - after a run both counts are zero; the request channel is not ready while
//   a run is in progress
// - when the receiver stalls, the result register holds its word and the
//   walk waits at the next match
// - reset clears counts, overflow flag and all valid state; list memories
//   need no clearing since only entries below the count are read
// ----------------------------------------------------------------------------
module sorted_list_intersection (
	input  logic       clk,
	input  logic       arst_n,
	slist_in_if.sink   request,
	slist_out_if.source result
);
	slist_pkg::dp_cmd_t    cmd;
	slist_pkg::dp_status_t status;
	logic                  in_accept;

	// a word moves when both sides agree
	assign in_accept = request.valid && request.ready;

	// sequencer: idle, read, compare, flush
	slist_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (request.valid),
		.in_command(request.command),
		.in_ready  (request.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// stores, pointers and the result register
	slist_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_accept       (in_accept),
		.in_command      (request.command),
		.in_value        (request.value),
		.cmd             (cmd),
		.status          (status),
		.out_ready       (result.ready),
		.out_valid       (result.valid),
		.out_common_value(result.common_value),
		.out_empty_result(result.empty_result),
		.out_overflowed  (result.overflowed),
		.out_last        (result.last)
	);
endmodule

// ===== design/slist_ram.sv =====
// ----------------------------------------------------------------------------
// slist_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module slist_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== design/slist_ctrl.sv =====
// ----------------------------------------------------------------------------
// slist_ctrl
// sequencer of the two-pointer walk
// ----------------------------------------------------------------------------
module slist_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [1:0]            in_command,
	output logic                  in_ready,
	input  slist_pkg::dp_status_t status,
	output slist_pkg::dp_cmd_t    cmd
);
	slist_pkg::state_t state_q, state_d;
	logic              run_accept;

	assign run_accept = in_valid && in_ready && (in_command == slist_pkg::CMD_RUN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= slist_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			slist_pkg::ST_IDLE: begin
				if (run_accept) state_d = slist_pkg::ST_READ;
			end
			slist_pkg::ST_READ: begin
				state_d = status.walk_go ? slist_pkg::ST_CMP : slist_pkg::ST_FLUSH;
			end
			slist_pkg::ST_CMP: begin
				if (!status.eq || !status.pend_valid || status.out_free)
					state_d = slist_pkg::ST_READ;
			end
			slist_pkg::ST_FLUSH: begin
				if (status.out_free) state_d = slist_pkg::ST_IDLE;
			end
			default: state_d = slist_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready      = 1'b0;
		cmd           = '0;
		unique case (state_q)
			slist_pkg::ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.run_start = run_accept;
			end
			slist_pkg::ST_READ: begin
			end
			slist_pkg::ST_CMP: begin
				if (status.eq) begin
					cmd.step_eq = !status.pend_valid || status.out_free;
				end else if (status.a_less) begin
					cmd.step_a = 1'b1;
				end else begin
					cmd.step_b = 1'b1;
				end
			end
			slist_pkg::ST_FLUSH: begin
				cmd.finish = status.out_free;
			end
			default: begin
			end
		endcase
	end
endmodule

// ===== design/slist_dp.sv =====
// ----------------------------------------------------------------------------
// slist_dp
// list stores, counts, walk pointers, pending match and result register
// ----------------------------------------------------------------------------
module slist_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_accept,
	input  logic [1:0]                          in_command,
	input  logic signed [slist_pkg::DATA_W-1:0] in_value,
	input  slist_pkg::dp_cmd_t                  cmd,
	output slist_pkg::dp_status_t               status,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic signed [slist_pkg::DATA_W-1:0] out_common_value,
	output logic                                out_empty_result,
	output logic                                out_overflowed,
	output logic                                out_last
);
	logic [slist_pkg::CNT_W-1:0]         count_a_q, count_b_q, i_q, j_q;
	logic [slist_pkg::NRES_W-1:0]        n_q;
	logic                                overflow_q;
	logic                                pend_valid_q;
	logic signed [slist_pkg::DATA_W-1:0] pend_val_q;
	logic                                out_valid_q;
	logic signed [slist_pkg::DATA_W-1:0] out_val_q;
	logic                                out_empty_q, out_ovf_q, out_last_q;

	logic                                wr_a, wr_b, full_a, full_b;
	logic [slist_pkg::DATA_W-1:0]        rdata_a, rdata_b;
	logic                                out_free, emit_pend;

	assign full_a = (count_a_q == slist_pkg::CNT_W'(slist_pkg::LIST_DEPTH));
	assign full_b = (count_b_q == slist_pkg::CNT_W'(slist_pkg::LIST_DEPTH));
	assign wr_a   = in_accept && (in_command == slist_pkg::CMD_APPEND_A) && !full_a;
	assign wr_b   = in_accept && (in_command == slist_pkg::CMD_APPEND_B) && !full_b;

	slist_ram #(.WIDTH(slist_pkg::DATA_W), .DEPTH(slist_pkg::LIST_DEPTH)) u_ram_a (
		.clk  (clk),
		.we   (wr_a),
		.waddr(count_a_q[slist_pkg::ADDR_W-1:0]),
		.wdata(in_value),
		.raddr(i_q[slist_pkg::ADDR_W-1:0]),
		.rdata(rdata_a)
	);

	slist_ram #(.WIDTH(slist_pkg::DATA_W), .DEPTH(slist_pkg::LIST_DEPTH)) u_ram_b (
		.clk  (clk),
		.we   (wr_b),
		.waddr(count_b_q[slist_pkg::ADDR_W-1:0]),
		.wdata(in_value),
		.raddr(j_q[slist_pkg::ADDR_W-1:0]),
		.rdata(rdata_b)
	);

	assign out_free  = !out_valid_q || out_ready;
	assign emit_pend = cmd.step_eq && pend_valid_q;

	assign status.walk_go    = (i_q < count_a_q) && (j_q < count_b_q)
		&& (n_q < slist_pkg::NRES_W'(slist_pkg::MAX_RESULTS));
	assign status.eq         = (rdata_a == rdata_b);
	assign status.a_less     = ($signed(rdata_a) < $signed(rdata_b));
	assign status.pend_valid = pend_valid_q;
	assign status.out_free   = out_free;

	// counts and sticky overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_a_q  <= '0;
			count_b_q  <= '0;
			overflow_q <= 1'b0;
		end else if (cmd.finish) begin
			count_a_q <= '0;
			count_b_q <= '0;
		end else begin
			if (wr_a) count_a_q <= count_a_q + 1'b1;
			if (wr_b) count_b_q <= count_b_q + 1'b1;
			if (in_accept && ((in_command == slist_pkg::CMD_APPEND_A && full_a)
				|| (in_command == slist_pkg::CMD_APPEND_B && full_b)))
				overflow_q <= 1'b1;
		end
	end

	// walk pointers and held match
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q          <= '0;
			j_q          <= '0;
			n_q          <= '0;
			pend_valid_q <= 1'b0;
		end else if (cmd.run_start) begin
			i_q          <= '0;
			j_q          <= '0;
			n_q          <= '0;
			pend_valid_q <= 1'b0;
		end else if (cmd.step_eq) begin
			i_q          <= i_q + 1'b1;
			j_q          <= j_q + 1'b1;
			n_q          <= n_q + 1'b1;
			pend_valid_q <= 1'b1;
		end else if (cmd.step_a) begin
			i_q <= i_q + 1'b1;
		end else if (cmd.step_b) begin
			j_q <= j_q + 1'b1;
		end else if (cmd.finish) begin
			// pointers follow the counts back to zero
			i_q          <= '0;
			j_q          <= '0;
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step_eq) pend_val_q <= $signed(rdata_a);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_pend || cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_pend || cmd.finish) begin
			out_val_q   <= pend_valid_q ? pend_val_q : '0;
			out_empty_q <= !pend_valid_q;
			out_ovf_q   <= overflow_q;
			out_last_q  <= cmd.finish;
		end
	end

	assign out_valid        = out_valid_q;
	assign out_common_value = out_val_q;
	assign out_empty_result = out_empty_q;
	assign out_overflowed   = out_ovf_q;
	assign out_last         = out_last_q;

	// checks
	a_ptr_a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		i_q <= count_a_q || cmd.finish || count_a_q == '0)
		else $error("pointer a ran past count a");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_a_q <= slist_pkg::CNT_W'(slist_pkg::LIST_DEPTH)
		&& count_b_q <= slist_pkg::CNT_W'(slist_pkg::LIST_DEPTH))
		else $error("list count beyond depth");
	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		overflow_q |=> overflow_q)
		else $error("overflow flag cleared");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !(emit_pend || cmd.finish))
		else $error("result register overwritten while stalled");
endmodule
